[hdl/slmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmm_pkg: shared types and constants of the sparse linear model scorer
// Sizes of the feature tables, fixed-point format, field widths and codes.
// ----------------------------------------------------------------------------
package slmm_pkg;

   // feature tables and fixed-point format
   localparam int FEATURES  = 1024;
   localparam int FRAC_BITS = 16;
   localparam int ADDR_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;

   // field widths
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 11;
   localparam int DATA_W    = 32;
   localparam int SCALE_W   = 31;
   localparam int ACC_W     = 48;
   localparam int SUM_W     = 64;
   localparam int CNT_W     = 32;
   localparam int OUT_W     = 63;
   localparam int CSR_IDX_W = 2;

   // shared multiplier
   localparam int MUL_W  = DATA_W + 1;
   localparam int PROD_W = 2 * MUL_W;

   // divider step counter
   localparam int DIV_STEP_W = $clog2(SUM_W);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ELEM   = 2'd1,
      MODE_END    = 2'd2,
      MODE_REPORT = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMALIZE = 2'd0,
      CSR_INTERCEPT = 2'd1,
      CSR_Y_SCALE   = 2'd2
   } csr_index_type;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

endpackage
`default_nettype wire

[hdl/slmm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmm_div: restoring divider for the error report
// Divides the 64-bit error sum by the 32-bit sample count, one quotient bit
// per cycle; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module slmm_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [slmm_pkg::SUM_W-1:0] dividend,
   input  wire logic [slmm_pkg::CNT_W-1:0] divisor,
   output logic                            done,
   output logic [slmm_pkg::SUM_W-1:0]      quotient
);
   import slmm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      dvs_ff, dvs_in;

   logic [CNT_W:0] trial;
   logic [CNT_W:0] trial_sub;
   logic           fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out the top as quotient bits shift in
         rem_in  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[hdl/sparse_linear_model_mse.sv]
`timescale 1ns / 1ps
`default_nettype none
// Load item: written to memory from IDLE. Sample element: MUL1, then MUL2 and
// MUL3 with normalization, then ACC, through the one shared 33x33 multiplier.
// End item: DIFF, SQ, END; the result is registered once the response is free.
// Report item: waits in DIV for the one-bit-per-cycle divider (RPT with no samples).
// Reset: synchronous; a clearing pass writes all 1024 entries of the weight and
// scale memory while req_stall stays high; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// sparse_linear_model_mse: sparse linear model scorer
// Accumulates weight times element over a sparse sample, returns prediction
// and squared error per sample and the mean squared error on report.
// ----------------------------------------------------------------------------
module sparse_linear_model_mse (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [slmm_pkg::MODE_W-1:0]           req_mode,
   input  wire logic [slmm_pkg::IDX_W-1:0]            req_feature_index,
   input  wire logic signed [slmm_pkg::DATA_W-1:0]    req_feature_value,
   input  wire logic [slmm_pkg::SCALE_W-1:0]          req_feature_scale,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_result_kind,
   output logic signed [slmm_pkg::ACC_W-1:0]          rsp_prediction,
   output logic [slmm_pkg::OUT_W-1:0]                 rsp_squared_error,
   output logic [slmm_pkg::OUT_W-1:0]                 rsp_mean_squared_error,
   output logic [slmm_pkg::CNT_W-1:0]                 rsp_sample_total,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [slmm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [slmm_pkg::DATA_W-1:0]           csr_data
);
   import slmm_pkg::*;

   localparam int MEM_W = SCALE_W + DATA_W;
   localparam int SUMX_W = ACC_W + 2;

   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);
   localparam logic [DATA_W-1:0]  SQ_LIMIT  = 32'd3037000499;
   localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

   localparam logic signed [PROD_W-1:0] Q32_MAX =
      {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] Q32_MIN = -Q32_MAX - 1;
   localparam logic signed [SUMX_W-1:0] ACC_MAX =
      {{(SUMX_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUMX_W-1:0] ACC_MIN = -ACC_MAX - 1;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_MUL1  = 11'b000_0000_0100,
      S_MUL2  = 11'b000_0000_1000,
      S_MUL3  = 11'b000_0001_0000,
      S_ACC   = 11'b000_0010_0000,
      S_DIFF  = 11'b000_0100_0000,
      S_SQ    = 11'b000_1000_0000,
      S_END   = 11'b001_0000_0000,
      S_DIV   = 11'b010_0000_0000,
      S_RPT   = 11'b100_0000_0000
   } state_type;

   // floor back to FRAC_BITS fraction bits, clamp to 32-bit signed
   function automatic logic signed [DATA_W-1:0] sat_q32(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p >>> FRAC_BITS;
      if (s > Q32_MAX) begin
         s = Q32_MAX;
      end else if (s < Q32_MIN) begin
         s = Q32_MIN;
      end
      return DATA_W'(s);
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUMX_W-1:0] x);
      logic signed [SUMX_W-1:0] s;
      s = x;
      if (s > ACC_MAX) begin
         s = ACC_MAX;
      end else if (s < ACC_MIN) begin
         s = ACC_MIN;
      end
      return ACC_W'(s);
   endfunction

   // control and architectural state
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic                      norm_ff, norm_in;
   logic signed [DATA_W-1:0]  icpt_ff, icpt_in;
   logic [SCALE_W-1:0]        yscale_ff, yscale_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]          esum_ff, esum_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [DATA_W-1:0]  val_ff, val_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   pred_ff, pred_in;
   logic [DATA_W-1:0]         ad_ff, ad_in;
   logic                      over_ff, over_in;
   logic [OUT_W-1:0]          mse_ff, mse_in;
   logic                      kind_ff, kind_in;
   logic signed [ACC_W-1:0]   pred_out_ff, pred_out_in;
   logic [OUT_W-1:0]          se_out_ff, se_out_in;
   logic [OUT_W-1:0]          mse_out_ff, mse_out_in;
   logic [CNT_W-1:0]          total_ff, total_in;

   // weight and scale memory, one entry per feature
   logic [MEM_W-1:0]          weight_mem [FEATURES];
   logic [MEM_W-1:0]          rdata_ff;
   logic                      mem_we;
   logic                      mem_re;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [MEM_W-1:0]          mem_wdata;

   // divider
   logic                      div_start;
   logic                      div_done;
   logic [SUM_W-1:0]          div_quot;

   // combinational helpers
   logic                      idx_ok;
   logic [ADDR_W-1:0]         req_addr;
   logic                      out_free;
   mode_type                  mode;
   logic signed [DATA_W-1:0]  rd_weight;
   logic [SCALE_W-1:0]        rd_scale;
   logic signed [DATA_W-1:0]  sat_w;
   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic                      mul_en;
   logic signed [PROD_W-1:0]  term;
   logic signed [SUMX_W-1:0]  acc_sum;
   logic signed [SUMX_W-1:0]  pred_sum;
   logic signed [SUMX_W-1:0]  diff;
   logic [SUMX_W-1:0]         ad_full;
   logic [SUM_W-1:0]          prod_u;
   logic [OUT_W-1:0]          se;
   logic [SUM_W:0]            esum_sum;
   logic [SUM_W-1:0]          esum_new;
   logic [CNT_W-1:0]          count_new;

   slmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (esum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      idx_ok   = (req_feature_index != '0) &&
                 (32'(req_feature_index) <= 32'(FEATURES));
      req_addr = ADDR_W'(req_feature_index - IDX_W'(1));
      out_free = !rsp_valid_ff || !rsp_stall;
      mode     = mode_type'(req_mode);

      rd_weight = $signed(rdata_ff[DATA_W-1:0]);
      rd_scale  = rdata_ff[MEM_W-1:DATA_W];
      sat_w     = sat_q32(prod_ff);

      // shared multiplier operand selection
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_MUL1: begin
            mul_a = MUL_W'(rd_weight);
            mul_b = norm_ff ? $signed({2'b00, rd_scale}) : MUL_W'(val_ff);
         end
         S_MUL2: begin
            mul_a = MUL_W'(sat_w);
            mul_b = $signed({2'b00, yscale_ff});
         end
         S_MUL3: begin
            mul_a = MUL_W'(sat_w);
            mul_b = MUL_W'(val_ff);
         end
         S_SQ: begin
            mul_a = $signed({1'b0, ad_ff});
            mul_b = $signed({1'b0, ad_ff});
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = mul_en ? (mul_a * mul_b) : prod_ff;

      term     = prod_ff >>> FRAC_BITS;
      acc_sum  = SUMX_W'(acc_ff) + SUMX_W'(term);
      pred_sum = SUMX_W'(acc_ff) + SUMX_W'(icpt_ff);
      diff     = SUMX_W'(val_ff) - SUMX_W'(pred_ff);
      ad_full  = (diff < 0) ? SUMX_W'(-diff) : SUMX_W'(diff);

      // unsigned square, saturated to 63 bits
      prod_u = prod_ff[SUM_W-1:0];
      if (over_ff || (prod_u > {1'b0, OUT_MAX})) begin
         se = OUT_MAX;
      end else begin
         se = prod_u[OUT_W-1:0];
      end
      esum_sum  = {1'b0, esum_ff} + {2'b00, se};
      esum_new  = esum_sum[SUM_W] ? '1 : esum_sum[SUM_W-1:0];
      count_new = (&count_ff) ? count_ff : count_ff + CNT_W'(1);

      state_in     = state_ff;
      clr_in       = clr_ff;
      norm_in      = norm_ff;
      icpt_in      = icpt_ff;
      yscale_in    = yscale_ff;
      acc_in       = acc_ff;
      esum_in      = esum_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      val_in       = val_ff;
      pred_in      = pred_ff;
      ad_in        = ad_ff;
      over_in      = over_ff;
      mse_in       = mse_ff;
      kind_in      = kind_ff;
      pred_out_in  = pred_out_ff;
      se_out_in    = se_out_ff;
      mse_out_in   = mse_out_ff;
      total_in     = total_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = req_addr;
      mem_wdata    = {req_feature_scale, req_feature_value};
      div_start    = 1'b0;

      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_NORMALIZE: norm_in   = csr_data[0];
            CSR_INTERCEPT: icpt_in   = $signed(csr_data);
            CSR_Y_SCALE:   yscale_in = csr_data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = {SCALE_ONE, {DATA_W{1'b0}}};
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(FEATURES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_feature_value;
               case (mode)
                  MODE_LOAD: begin
                     mem_we = idx_ok;
                  end
                  MODE_ELEM: begin
                     // out-of-range elements add nothing
                     if (idx_ok) begin
                        mem_re   = 1'b1;
                        state_in = S_MUL1;
                     end
                  end
                  MODE_END: begin
                     pred_in  = sat_acc(pred_sum);
                     state_in = S_DIFF;
                  end
                  MODE_REPORT: begin
                     if (count_ff == '0) begin
                        mse_in   = '0;
                        state_in = S_RPT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL1: begin
            state_in = norm_ff ? S_MUL2 : S_ACC;
         end
         S_MUL2: begin
            state_in = S_MUL3;
         end
         S_MUL3: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = sat_acc(acc_sum);
            state_in = S_IDLE;
         end
         S_DIFF: begin
            ad_in    = ad_full[DATA_W-1:0];
            over_in  = ad_full > SUMX_W'(SQ_LIMIT);
            state_in = S_SQ;
         end
         S_SQ: begin
            state_in = S_END;
         end
         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_SAMPLE;
               pred_out_in  = pred_ff;
               se_out_in    = se;
               mse_out_in   = '0;
               total_in     = count_new;
               esum_in      = esum_new;
               count_in     = count_new;
               acc_in       = '0;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mse_in   = div_quot[SUM_W-1] ? OUT_MAX : div_quot[OUT_W-1:0];
               state_in = S_RPT;
            end
         end
         S_RPT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_REPORT;
               pred_out_in  = '0;
               se_out_in    = '0;
               mse_out_in   = mse_ff;
               total_in     = count_ff;
               acc_in       = '0;
               esum_in      = '0;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         norm_ff      <= 1'b0;
         icpt_ff      <= '0;
         yscale_ff    <= SCALE_ONE;
         acc_ff       <= '0;
         esum_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         norm_ff      <= norm_in;
         icpt_ff      <= icpt_in;
         yscale_ff    <= yscale_in;
         acc_ff       <= acc_in;
         esum_ff      <= esum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      prod_ff     <= prod_in;
      pred_ff     <= pred_in;
      ad_ff       <= ad_in;
      over_ff     <= over_in;
      mse_ff      <= mse_in;
      kind_ff     <= kind_in;
      pred_out_ff <= pred_out_in;
      se_out_ff   <= se_out_in;
      mse_out_ff  <= mse_out_in;
      total_ff    <= total_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= weight_mem[req_addr];
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_prediction         = pred_out_ff;
   assign rsp_squared_error      = se_out_ff;
   assign rsp_mean_squared_error = mse_out_ff;
   assign rsp_sample_total       = total_ff;

endmodule
`default_nettype wire
